// ----- sv/tef_pkg.sv -----
package tef_pkg;

    localparam int SIG_W            = 32;
    localparam int SIGNUM_W         = 5;
    localparam int THREAD_W         = 3;
    localparam int THREAD_COUNT_DEF = 8;

    typedef enum logic [1:0] {
        FUNC_SET   = 2'd0,
        FUNC_WAIT  = 2'd1,
        FUNC_ALLOC = 2'd2,
        FUNC_FREE  = 2'd3
    } t_func;

    typedef struct packed {
        t_func                func;
        logic [THREAD_W-1:0]  thread_index;
        logic [SIG_W-1:0]     mask_bits;
        logic [SIGNUM_W-1:0]  signal_index;
    } t_tef_in;

    typedef struct packed {
        logic [SIG_W-1:0]     received_bits;
        logic                 must_block;
        logic                 woke_thread;
        logic [SIGNUM_W-1:0]  allocated_number;
        logic                 none_free;
    } t_tef_out;

    typedef struct packed {
        logic [SIG_W-1:0] received;
        logic [SIG_W-1:0] waiting;
        logic [SIG_W-1:0] reserved;
    } t_tef_flags;

endpackage

// ----- sv/thread_event_flag_unit.sv -----
// Per-thread event flags with signal-number allocation. A beat is taken on every clock
// edge where start is high; busy is always low, so one item per cycle is sustained. The
// result is driven on o_result with o_strobe once the item has passed the input register
// and then one pass through the flag update into the result register. It is shown for
// one cycle only, as the receiver cannot stall. An item may target the same thread as
// the one just before it; the flag state it sees already holds that update.
// Items naming a thread at or above THREAD_COUNT leave state untouched and return zeros.
module thread_event_flag_unit #(
    parameter int THREAD_COUNT = tef_pkg::THREAD_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  tef_pkg::t_tef_in i_in,
    output logic             busy,
    output logic             o_strobe,
    output tef_pkg::t_tef_out o_result
);
    import tef_pkg::*;

    // only eight thread numbers can be named, so storage stops there
    localparam int DEPTH = (THREAD_COUNT < (1 << THREAD_W)) ? THREAD_COUNT : (1 << THREAD_W);
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic       r_vld;
    t_tef_in    r_in;
    t_tef_flags r_flags [DEPTH];
    logic       r_strobe;
    t_tef_out   r_result;

    logic       w_accept;
    logic       w_in_range;
    logic [IW-1:0] w_idx;
    t_tef_flags w_cur;
    t_tef_flags w_new;
    t_tef_out   w_op_result;
    t_tef_out   n_result;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    assign w_in_range = 32'(r_in.thread_index) < 32'(THREAD_COUNT);
    assign w_idx      = r_in.thread_index[IW-1:0];
    assign w_cur      = r_flags[w_idx];
    assign n_result   = w_in_range ? w_op_result : '0;

    tef_op_unit u_op (
        .i_in     (r_in),
        .i_flags  (w_cur),
        .o_flags  (w_new),
        .o_result (w_op_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= 1'b0;
            r_strobe <= 1'b0;
            for (int t = 0; t < DEPTH; t++) begin
                r_flags[t] <= '0;
            end
        end else begin
            r_vld    <= w_accept;
            r_strobe <= r_vld;
            if (r_vld && w_in_range) begin
                r_flags[w_idx] <= w_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in;
        end
        if (r_vld) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ----- sv/tef_op_unit.sv -----
module tef_op_unit (
    input  tef_pkg::t_tef_in    i_in,
    input  tef_pkg::t_tef_flags i_flags,
    output tef_pkg::t_tef_flags o_flags,
    output tef_pkg::t_tef_out   o_result
);
    import tef_pkg::*;

    logic [SIG_W-1:0]    w_got;
    logic [SIG_W-1:0]    w_hit;
    logic                w_free_found;
    logic [SIGNUM_W-1:0] w_free_num;
    logic [SIG_W-1:0]    w_free_bit;
    logic [SIG_W-1:0]    w_rel_bit;

    assign w_got      = i_in.mask_bits & i_flags.received;
    assign w_hit      = i_in.mask_bits & i_flags.waiting;
    assign w_free_bit = {{(SIG_W-1){1'b0}}, 1'b1} << w_free_num;
    assign w_rel_bit  = {{(SIG_W-1){1'b0}}, 1'b1} << i_in.signal_index;

    // lowest clear reserved bit
    always_comb begin
        w_free_found = 1'b0;
        w_free_num   = '0;
        for (int i = SIG_W - 1; i >= 0; i--) begin
            if (!i_flags.reserved[i]) begin
                w_free_found = 1'b1;
                w_free_num   = SIGNUM_W'(i);
            end
        end
    end

    always_comb begin
        o_flags  = i_flags;
        o_result = '0;
        case (i_in.func)
            FUNC_SET: begin
                o_flags.received = i_flags.received | i_in.mask_bits;
                if (w_hit != '0) begin
                    o_flags.waiting      = i_flags.waiting & ~i_in.mask_bits;
                    o_result.woke_thread = 1'b1;
                end
            end
            FUNC_WAIT: begin
                if (w_got != '0) begin
                    o_flags.received       = i_flags.received & ~w_got;
                    o_result.received_bits = w_got;
                end else begin
                    o_flags.waiting     = i_in.mask_bits;
                    o_result.must_block = 1'b1;
                end
            end
            FUNC_ALLOC: begin
                if (w_free_found) begin
                    o_flags.reserved          = i_flags.reserved | w_free_bit;
                    o_flags.received          = i_flags.received & ~w_free_bit;
                    o_result.allocated_number = w_free_num;
                end else begin
                    o_result.none_free = 1'b1;
                end
            end
            FUNC_FREE: begin
                o_flags.reserved = i_flags.reserved & ~w_rel_bit;
            end
            default: begin
                o_flags  = i_flags;
                o_result = '0;
            end
        endcase
    end

endmodule

// ----- sv/tef_checker.sv -----
module tef_checker #(
    parameter int THREAD_COUNT = tef_pkg::THREAD_COUNT_DEF
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input tef_pkg::t_tef_in  i_in,
    input logic              busy,
    input logic              o_strobe,
    input tef_pkg::t_tef_out o_result
);
    import tef_pkg::*;

    // every accepted beat gives exactly one result on o_strobe
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_strobe)
        else $error("accepted beat produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 2))
        else $error("result without an accepted beat");

    a_fields_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (!(o_result.must_block && o_result.woke_thread)
            && (!o_result.must_block || o_result.received_bits == '0)
            && (!o_result.none_free || o_result.allocated_number == '0)))
        else $error("inconsistent result fields");

    a_bad_thread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (32'(i_in.thread_index) >= 32'(THREAD_COUNT)))
            |=> ##1 (o_result == '0))
        else $error("out-of-range thread gave a nonzero result");

endmodule

bind thread_event_flag_unit tef_checker #(.THREAD_COUNT(THREAD_COUNT)) u_tef_checker (.*);

// ----- bench/thread_event_flag_unit_checker.sv -----
`timescale 1ns / 1ps

module thread_event_flag_unit_checker #(
    parameter int THREAD_COUNT = tef_pkg::THREAD_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  tef_pkg::t_tef_in  i_item,
    input  logic              i_strobe,
    input  tef_pkg::t_tef_out i_result,
    output int                o_fail_count,
    output int                o_pending
);
    import tef_pkg::*;

    logic [SIG_W-1:0] rcv_flags [THREAD_COUNT];
    logic [SIG_W-1:0] wait_flags [THREAD_COUNT];
    logic [SIG_W-1:0] rsv_flags [THREAD_COUNT];

    t_tef_out flag_results_due [$];
    int       beat_count;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        beat_count   = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] result %0d: %s got %0h want %0h", $realtime, beat_count, what,
                 got, want);
        o_fail_count++;
    endtask

    // updates the flag state for one beat and returns the result it should give
    function automatic t_tef_out predict_flag_op(input t_tef_in item);
        t_tef_out         res;
        int               th;
        logic [SIG_W-1:0] got;
        logic             found;
        res   = '0;
        th    = int'(item.thread_index);
        found = 1'b0;
        if (th >= THREAD_COUNT)
            return res;
        case (item.func)
            FUNC_SET: begin
                rcv_flags[th] |= item.mask_bits;
                if ((item.mask_bits & wait_flags[th]) != '0) begin
                    wait_flags[th] &= ~item.mask_bits;
                    res.woke_thread = 1'b1;
                end
            end
            FUNC_WAIT: begin
                got = item.mask_bits & rcv_flags[th];
                if (got != '0) begin
                    rcv_flags[th] &= ~got;
                    res.received_bits = got;
                end else begin
                    wait_flags[th] = item.mask_bits;
                    res.must_block = 1'b1;
                end
            end
            FUNC_ALLOC: begin
                for (int i = 0; i < SIG_W; i++) begin
                    if (!found && !rsv_flags[th][i]) begin
                        rsv_flags[th][i] = 1'b1;
                        rcv_flags[th][i] = 1'b0;
                        res.allocated_number = SIGNUM_W'(i);
                        found = 1'b1;
                    end
                end
                if (!found)
                    res.none_free = 1'b1;
            end
            default: begin
                rsv_flags[th][item.signal_index] = 1'b0;
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_tef_out want;
        if (!i_rst_n) begin
            for (int t = 0; t < THREAD_COUNT; t++) begin
                rcv_flags[t]  = '0;
                wait_flags[t] = '0;
                rsv_flags[t]  = '0;
            end
            flag_results_due.delete();
        end else begin
            if (i_start && !i_busy)
                flag_results_due.push_back(predict_flag_op(i_item));
            if (i_strobe) begin
                if (flag_results_due.size() == 0) begin
                    report_mismatch("result with nothing outstanding", 0, 0);
                end else begin
                    want = flag_results_due.pop_front();
                    if (i_result.received_bits !== want.received_bits)
                        report_mismatch("received_bits", i_result.received_bits,
                                        want.received_bits);
                    if (i_result.must_block !== want.must_block)
                        report_mismatch("must_block", 32'(i_result.must_block),
                                        32'(want.must_block));
                    if (i_result.woke_thread !== want.woke_thread)
                        report_mismatch("woke_thread", 32'(i_result.woke_thread),
                                        32'(want.woke_thread));
                    if (i_result.allocated_number !== want.allocated_number)
                        report_mismatch("allocated_number", 32'(i_result.allocated_number),
                                        32'(want.allocated_number));
                    if (i_result.none_free !== want.none_free)
                        report_mismatch("none_free", 32'(i_result.none_free),
                                        32'(want.none_free));
                end
                beat_count++;
            end
        end
        o_pending = flag_results_due.size();
    end

endmodule

// ----- bench/thread_event_flag_unit_test.sv -----
`timescale 1ns / 1ps

module thread_event_flag_unit_test;
    import tef_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int ITEMS_PER_PASS = 500;
    localparam int TAIL_CYCLES    = 8;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    t_tef_in  i_in;
    logic     busy;
    logic     o_strobe;
    t_tef_out o_result;

    int fail_count;
    int pending;
    int cycle_count;
    int idle_pct;
    int items_sent;

    thread_event_flag_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_in     (i_in),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    thread_event_flag_unit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_in),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    initial begin
        cycle_count = 0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("thread_event_flag_unit: mismatch");
            $finish;
        end
    end

    function automatic logic [SIG_W-1:0] rand_mask();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return 32'd1 << $urandom_range(31);
            3: return $urandom();
            4: return $urandom() & $urandom() & $urandom();
            default: return (32'd1 << $urandom_range(31)) | (32'd1 << $urandom_range(31));
        endcase
    endfunction

    // called just after a falling edge; returns just after a falling edge, once the item has been taken
    task automatic send_op(input t_func f, input int th, input logic [SIG_W-1:0] m,
                           input int sig);
        t_tef_in     item;
        logic [63:0] noise;
        item.func         = f;
        item.thread_index = THREAD_W'(th);
        item.mask_bits    = m;
        item.signal_index = SIGNUM_W'(sig);
        while ($urandom_range(99) < idle_pct) begin
            noise = {$urandom(), $urandom()};
            start <= 1'b0;
            i_in  <= noise[$bits(t_tef_in)-1:0];
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_in  <= item;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic alloc_burst(input int th, input int count);
        repeat (count)
            send_op(FUNC_ALLOC, th, rand_mask(), $urandom_range(31));
    endtask

    task automatic run_episode();
        int th;
        logic [SIG_W-1:0] m;
        th = $urandom_range(7);
        m  = rand_mask();
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                send_op(t_func'($urandom_range(3)), th, m, $urandom_range(31));
            end
            4, 5: begin
                send_op(FUNC_SET, th, m, $urandom_range(31));
                send_op(FUNC_WAIT, th, ($urandom_range(1) ? m : m | rand_mask()),
                        $urandom_range(31));
            end
            6: begin
                // drain, block on the mask, then wake with part of it
                send_op(FUNC_WAIT, th, m, $urandom_range(31));
                send_op(FUNC_WAIT, th, m, $urandom_range(31));
                send_op(FUNC_SET, th, m & ($urandom_range(1) ? '1 : $urandom()),
                        $urandom_range(31));
            end
            7: begin
                alloc_burst(th, $urandom_range(30, 34));
                repeat ($urandom_range(1, 3))
                    send_op(FUNC_FREE, th, rand_mask(), $urandom_range(31));
            end
            8: begin
                repeat ($urandom_range(1, 4))
                    send_op(FUNC_FREE, th, rand_mask(), $urandom_range(31));
            end
            default: begin
                send_op(FUNC_SET, th, '1, $urandom_range(31));
                send_op(FUNC_ALLOC, th, m, $urandom_range(31));
                send_op(FUNC_WAIT, th, '1, $urandom_range(31));
            end
        endcase
    endtask

    initial begin
        int pass_pct [3];
        pass_pct   = '{0, 63, 19};
        idle_pct   = 0;
        items_sent = 0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_in       = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        send_op(FUNC_SET,   0, 32'hFFFF_FFFF, 0);
        send_op(FUNC_WAIT,  0, 32'h0000_0000, 31);
        send_op(FUNC_WAIT,  0, 32'h0000_00F0, 0);
        send_op(FUNC_WAIT,  0, 32'hFFFF_FFFF, 0);
        send_op(FUNC_WAIT,  0, 32'h8000_0001, 0);
        send_op(FUNC_SET,   0, 32'h8000_0000, 0);
        send_op(FUNC_SET,   0, 32'h0000_0001, 0);
        send_op(FUNC_ALLOC, 7, 32'hFFFF_FFFF, 31);
        send_op(FUNC_ALLOC, 7, 32'h0000_0000, 0);
        send_op(FUNC_FREE,  7, 32'h0000_0000, 0);
        send_op(FUNC_FREE,  7, 32'hFFFF_FFFF, 31);
        send_op(FUNC_ALLOC, 7, 32'h0000_0000, 0);
        send_op(FUNC_SET,   7, 32'hFFFF_FFFF, 0);
        send_op(FUNC_ALLOC, 7, 32'h0000_0000, 0);
        send_op(FUNC_WAIT,  7, 32'hFFFF_FFFF, 0);
        send_op(FUNC_SET,   3, 32'h5555_5555, 0);
        send_op(FUNC_WAIT,  3, 32'hAAAA_AAAA, 0);
        send_op(FUNC_SET,   3, 32'h0000_0002, 0);
        send_op(FUNC_FREE,  3, 32'h0000_0000, 31);

        // exhaust one thread so alloc reports none free, then free and retake
        alloc_burst(5, 33);
        send_op(FUNC_FREE,  5, 32'h0000_0000, 17);
        send_op(FUNC_ALLOC, 5, 32'h0000_0000, 0);

        foreach (pass_pct[p]) begin
            idle_pct   = pass_pct[p];
            items_sent = 0;
            while (items_sent < ITEMS_PER_PASS)
                run_episode();
        end

        start <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("thread_event_flag_unit: match");
        else
            $display("thread_event_flag_unit: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/tef_pkg.sv
sv/tef_op_unit.sv
sv/thread_event_flag_unit.sv
sv/tef_checker.sv
bench/thread_event_flag_unit_checker.sv
bench/thread_event_flag_unit_test.sv
